// ----- rtl/categorical_sampler_assert.svh -----
// Assertion macros for the categorical sampler RTL.
`ifndef CATEGORICAL_SAMPLER_ASSERT_SVH
`define CATEGORICAL_SAMPLER_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define CS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/cs_pkg.sv -----
// Shared types and constants of the categorical sampler.
`default_nettype none
package cs_pkg;

  // Fixed field widths of the stream beats and the configuration register.
  localparam int INDEX_W   = 6;
  localparam int WEIGHT_W  = 16;
  localparam int UNIFORM_W = 32;
  localparam int COUNT_W   = 7;

  // Command codes carried in the input tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_DRAW  = 1'b1;

  // Status codes carried in the output tuser.
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Flags of the token that walks the chain of weight cells.
  typedef struct packed {
    logic valid;
    logic found;
  } cs_flag_t;

  // Controls broadcast from the sequencer to every cell.
  typedef struct packed {
    logic kill;
    logic wr_en;
  } cs_bcast_t;

endpackage
`default_nettype wire

// ----- rtl/cs_cell.sv -----
// One weight cell of the sampler chain: holds a weight and extends the running prefix.
`default_nettype none
module cs_cell #(
  parameter int INDEX       = 0,
  parameter int WEIGHT_BITS = 16,
  parameter int TOTAL_BITS  = 22,
  parameter int CNT_BITS    = 7,
  parameter int PICK_BITS   = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cs_pkg::cs_bcast_t         bcast,
  input  logic [cs_pkg::INDEX_W-1:0] wr_index,
  input  logic [WEIGHT_BITS-1:0]    wr_weight,
  input  logic [CNT_BITS-1:0]       count,
  input  logic [TOTAL_BITS-1:0]     target,
  input  cs_pkg::cs_flag_t          in_flag,
  input  logic [TOTAL_BITS-1:0]     in_prefix,
  input  logic [PICK_BITS-1:0]      in_pick,
  output cs_pkg::cs_flag_t          out_flag,
  output logic [TOTAL_BITS-1:0]     out_prefix,
  output logic [PICK_BITS-1:0]      out_pick
);
  import cs_pkg::*;

  logic [WEIGHT_BITS-1:0] weight;
  logic                   active;
  logic [TOTAL_BITS-1:0]  sum;
  logic                   hit;

  // A cell at or above the in-use count adds nothing and never wins.
  assign active = (32'(count) > 32'(INDEX));
  assign sum    = in_prefix + (active ? TOTAL_BITS'(weight) : '0);
  assign hit    = active && !in_flag.found && (sum > target);

  always_ff @(posedge clk) begin
    if (rst) begin
      weight   <= '0;
      out_flag <= '0;
    end else begin
      if (bcast.wr_en && (32'(wr_index) == 32'(INDEX))) begin
        weight <= wr_weight;
      end
      out_flag.valid <= in_flag.valid && !bcast.kill;
      out_flag.found <= in_flag.found || hit;
    end
  end

  always_ff @(posedge clk) begin
    out_prefix <= sum;
    out_pick   <= hit ? PICK_BITS'(INDEX) : in_pick;
  end

endmodule
`default_nettype wire

// ----- rtl/categorical_sampler.sv -----
// Top level of the categorical sampler: beat handshakes, sequencer and the chain of weight cells.
`default_nettype none
`include "categorical_sampler_assert.svh"
// The sampler keeps one unsigned weight per category in a row of cells and
// draws a category by inverse CDF. A write beat stores a weight and returns
// its index; a draw beat scales its 32-bit uniform value by the total of the
// weights in use and returns the first category whose running sum exceeds
// that target, so a category of weight zero is never drawn. When the weights
// in use add up to zero a draw returns index 0 with the error status. The
// block works on one beat at a time. A draw passes from acceptance through
// the split 32-bit multiply that scales the target (S_MUL_LO, S_MUL_HI and
// S_ADD), a launch state, and the search token's walk along the chain at
// one cell per cycle, to a loaded result. A write instead walks the token
// along the chain to refresh the total. A draw against a zero total goes
// straight to the done state. Writing category_count starts the same
// refresh walk, during which s_tready is low. A result waiting in the
// output register does not block acceptance of the next beat; only loading
// the following result waits for it.
module categorical_sampler #(
  parameter int MAX_CATEGORIES = 64,
  parameter int WEIGHT_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // entry_index [5:0], weight [21:6], uniform [53:22], zero pad
  input  logic        s_tuser,  // command
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,  // sample_index [5:0], zero pad
  output logic        m_tuser,  // status
  // Configuration: category_count.
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);
  import cs_pkg::*;

  localparam int CNT_BITS   = $clog2(MAX_CATEGORIES + 1);
  localparam int PICK_BITS  = $clog2(MAX_CATEGORIES);
  // N weights of WEIGHT_BITS each always fit in this many bits.
  localparam int TOTAL_BITS = WEIGHT_BITS + PICK_BITS;
  // The total is split in two halves so that each multiply stays narrow.
  localparam int HALF_BITS  = (TOTAL_BITS + 1) / 2;
  localparam int PART_BITS  = UNIFORM_W + HALF_BITS;
  localparam int PROD_BITS  = UNIFORM_W + TOTAL_BITS;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SUM_GO    = 4'd1;
  localparam logic [3:0] S_SUM_WAIT  = 4'd2;
  localparam logic [3:0] S_MUL_LO    = 4'd3;
  localparam logic [3:0] S_MUL_HI    = 4'd4;
  localparam logic [3:0] S_ADD       = 4'd5;
  localparam logic [3:0] S_FIND_GO   = 4'd6;
  localparam logic [3:0] S_FIND_WAIT = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  // Input beat fields.
  logic [INDEX_W-1:0]   in_index;
  logic [WEIGHT_W-1:0]  in_weight;
  logic [UNIFORM_W-1:0] in_uniform;
  logic                 in_command;
  logic                 accept;
  logic                 res_load;

  assign in_index   = s_tdata[5:0];
  assign in_weight  = s_tdata[21:6];
  assign in_uniform = s_tdata[53:22];
  assign in_command = s_tuser;

  // Sequencer state.
  logic [3:0]            state;
  logic                  from_cfg;
  logic [CNT_BITS-1:0]   count;
  logic [TOTAL_BITS-1:0] total;
  logic [UNIFORM_W-1:0]  uniform;
  logic [PART_BITS-1:0]  part;
  logic [PART_BITS-1:0]  part_lo;
  logic [TOTAL_BITS-1:0] target;
  logic [INDEX_W-1:0]    res_index;
  logic                  res_status;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_status;

  logic [31:0]           cfg_sat;
  logic [PROD_BITS-1:0]  scaled;
  logic [HALF_BITS-1:0]  total_lo;
  logic [HALF_BITS-1:0]  total_hi;
  cs_bcast_t             bcast;

  // Chain links: link 0 is driven by the sequencer, link k leaves cell k-1.
  cs_flag_t              flag_link   [MAX_CATEGORIES+1];
  logic [TOTAL_BITS-1:0] prefix_link [MAX_CATEGORIES+1];
  logic [PICK_BITS-1:0]  pick_link   [MAX_CATEGORIES+1];

  // No beat is taken in reset or in the cycle of a configuration write.
  assign s_tready = (state == S_IDLE) && !cfg_we && !rst;
  assign accept   = s_tvalid && s_tready;

  // The output register takes a new result once the old one has left.
  assign res_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign bcast.kill  = cfg_we;
  assign bcast.wr_en = accept && (in_command == CMD_WRITE);

  // The count saturates at the number of cells.
  assign cfg_sat = (32'(cfg_data) > 32'(MAX_CATEGORIES)) ? 32'(MAX_CATEGORIES)
                                                         : 32'(cfg_data);

  assign total_lo = total[HALF_BITS-1:0];
  assign total_hi = HALF_BITS'(total[TOTAL_BITS-1:HALF_BITS]);
  // uniform * total = uniform * lo + (uniform * hi) << HALF_BITS.
  assign scaled   = PROD_BITS'(part_lo) + (PROD_BITS'(part) << HALF_BITS);

  // A token enters the chain in the launch cycle of each walk.
  assign flag_link[0].valid = (state == S_SUM_GO) || (state == S_FIND_GO);
  assign flag_link[0].found = 1'b0;
  assign prefix_link[0]     = '0;
  assign pick_link[0]       = '0;

  for (genvar k = 0; k < MAX_CATEGORIES; k++) begin : g_cell
    cs_cell #(
      .INDEX      (k),
      .WEIGHT_BITS(WEIGHT_BITS),
      .TOTAL_BITS (TOTAL_BITS),
      .CNT_BITS   (CNT_BITS),
      .PICK_BITS  (PICK_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .bcast     (bcast),
      .wr_index  (in_index),
      .wr_weight (WEIGHT_BITS'(in_weight)),
      .count     (count),
      .target    (target),
      .in_flag   (flag_link[k]),
      .in_prefix (prefix_link[k]),
      .in_pick   (pick_link[k]),
      .out_flag  (flag_link[k+1]),
      .out_prefix(prefix_link[k+1]),
      .out_pick  (pick_link[k+1])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      from_cfg <= 1'b0;
      count    <= CNT_BITS'(1);
      total    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // A new count flushes any walk in flight and starts a fresh total.
      if (cfg_we) begin
        count    <= cfg_sat[CNT_BITS-1:0];
        from_cfg <= 1'b1;
        state    <= S_SUM_GO;
      end else begin
        unique case (state)
          S_IDLE: begin
            if (accept) begin
              from_cfg <= 1'b0;
              if (in_command == CMD_WRITE) begin
                state <= S_SUM_GO;
              end else if (total == '0) begin
                state <= S_DONE;
              end else begin
                state <= S_MUL_LO;
              end
            end
          end
          S_SUM_GO:    state <= S_SUM_WAIT;
          S_SUM_WAIT: begin
            if (flag_link[MAX_CATEGORIES].valid) begin
              total <= prefix_link[MAX_CATEGORIES];
              state <= from_cfg ? S_IDLE : S_DONE;
            end
          end
          S_MUL_LO:    state <= S_MUL_HI;
          S_MUL_HI:    state <= S_ADD;
          S_ADD:       state <= S_FIND_GO;
          S_FIND_GO:   state <= S_FIND_WAIT;
          S_FIND_WAIT: begin
            if (flag_link[MAX_CATEGORIES].valid) begin
              state <= S_DONE;
            end
          end
          S_DONE: begin
            if (res_load) begin
              state <= S_IDLE;
            end
          end
          default:     state <= S_IDLE;
        endcase
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      uniform <= in_uniform;
      if (in_command == CMD_WRITE) begin
        res_index  <= in_index;
        res_status <= STATUS_OK;
      end else begin
        res_index  <= '0;
        res_status <= STATUS_EMPTY;
      end
    end
    if (state == S_MUL_LO) begin
      part <= PART_BITS'(uniform) * PART_BITS'(total_lo);
    end
    if (state == S_MUL_HI) begin
      part_lo <= part;
      part    <= PART_BITS'(uniform) * PART_BITS'(total_hi);
    end
    if (state == S_ADD) begin
      target <= scaled[PROD_BITS-1:UNIFORM_W];
    end
    if ((state == S_FIND_WAIT) && flag_link[MAX_CATEGORIES].valid) begin
      res_index  <= INDEX_W'(pick_link[MAX_CATEGORIES]);
      res_status <= STATUS_OK;
    end
    if (res_load) begin
      out_index  <= res_index;
      out_status <= res_status;
    end
  end

  assign m_tdata = {2'b00, out_index};
  assign m_tuser = out_status;

  // A token only reaches the end of the chain while a walk is awaited.
  `CS_ASSERT_SAME(a_token_in_walk, flag_link[MAX_CATEGORIES].valid, (state == S_SUM_WAIT) || (state == S_FIND_WAIT), "chain token outside a walk")
  // The target lies below the total, so every search finds a category.
  `CS_ASSERT_SAME(a_search_hits, (state == S_FIND_WAIT) && flag_link[MAX_CATEGORIES].valid, flag_link[MAX_CATEGORIES].found, "search walked off the chain")
  `CS_ASSERT_SAME(a_target_below, state == S_FIND_WAIT, target < total, "scaled target not below total")
  // Results are only loaded from the done state.
  `CS_ASSERT_SAME(a_load_from_done, $rose(m_tvalid), $past(state) == S_DONE, "result loaded outside done state")

endmodule
`default_nettype wire

// ----- tb/categorical_sampler_tb.sv -----
// Self-checking testbench for the categorical sampler: directed and random beats checked against a predictor.
`timescale 1ns / 1ps

module categorical_sampler_tb;
  import cs_pkg::*;

  // One input beat as the stimulus sees it, before it is packed onto the bus.
  typedef struct packed {
    logic                 cmd;
    logic [INDEX_W-1:0]   idx;
    logic [WEIGHT_W-1:0]  weight;
    logic [UNIFORM_W-1:0] uniform;
  } sampler_cmd_t;

  // One result beat: the chosen or echoed category and the status flag.
  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               status;
  } sample_t;

  localparam int NUM_CATS = 64;
  // A draw in the block finishes well within this window; a result seen in it after the
  // last result means the block produced something it should not have.
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 500;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;   // entry_index [5:0], weight [21:6], uniform [53:22], zero pad
  logic        s_tuser = 1'b0; // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // sample_index [5:0], zero pad
  logic        m_tuser;        // status
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_data = '0;

  categorical_sampler u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Commands waiting to be offered, and the results the predictor expects,
  // oldest first.
  sampler_cmd_t cmd_q[$];
  sample_t      expected_samples[$];
  sampler_cmd_t cur_cmd;

  // Predictor state: its own copy of the weight table, the running total of
  // the categories in use and the category count register.
  logic [WEIGHT_W-1:0] wt_table[NUM_CATS];
  logic [21:0]         wt_total = '0;
  logic [COUNT_W-1:0]  cat_count = 7'd1;

  // Both sides stop idling while quiet is set; hold keeps the receiver off.
  bit quiet = 1'b0;
  bit hold = 1'b0;
  bit pressure_go = 1'b0;
  int fail_count = 0;

  initial begin
    for (int i = 0; i < NUM_CATS; i++) wt_table[i] = '0;
  end

  // Counts above the table size saturate at the table size.
  function automatic int unsigned cats_in_use();
    return (cat_count > NUM_CATS) ? NUM_CATS : cat_count;
  endfunction

  function automatic void refresh_total();
    logic [21:0] sum;
    sum = '0;
    for (int i = 0; i < cats_in_use(); i++) sum = sum + wt_table[i];
    wt_total = sum;
  endfunction

  // Applies one accepted beat to the predictor state and returns the result
  // the block has to produce for it.
  function automatic sample_t predict_sample(sampler_cmd_t c);
    sample_t     r;
    logic [63:0] target;
    logic [21:0] running;
    bit          found;
    r.index = c.idx;
    r.status = STATUS_OK;
    if (c.cmd == CMD_WRITE) begin
      // Only categories in use contribute to the total; the weight is stored
      // either way.
      if (c.idx < cats_in_use()) wt_total = wt_total - wt_table[c.idx] + c.weight;
      wt_table[c.idx] = c.weight;
    end else if (wt_total == 0) begin
      r.index = '0;
      r.status = STATUS_EMPTY;
    end else begin
      // The target is floor(uniform * total / 2^32), always below the total,
      // so the walk always finds a category with a nonzero weight.
      target = (64'(c.uniform) * 64'(wt_total)) >> 32;
      running = '0;
      found = 1'b0;
      r.index = '0;
      for (int i = 0; i < cats_in_use(); i++) begin
        running = running + wt_table[i];
        if (!found && running > target) begin
          r.index = i[INDEX_W-1:0];
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Driver: moves one beat per handshake from the command queue onto the
  // input bus. The beat on the bus is predicted at the edge that accepts it.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) expected_samples.insert(expected_samples.size(), predict_sample(cur_cmd));
      if (cmd_q.size() != 0 && (quiet || $urandom_range(99) >= 36)) begin
        cur_cmd = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, cur_cmd.uniform, cur_cmd.weight, cur_cmd.idx};
        s_tuser <= cur_cmd.cmd;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result beat against the oldest expectation
  // and drives the receiver's ready, idling at random unless held or quiet.
  always @(posedge clk) begin
    sample_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d status %0d",
                                    m_tdata[INDEX_W-1:0], m_tuser));
        end else begin
          want = expected_samples.pop_front();
          if (m_tdata[INDEX_W-1:0] !== want.index)
            report_mismatch($sformatf("sample_index %0d, expected %0d",
                                      m_tdata[INDEX_W-1:0], want.index));
          if (m_tuser !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", m_tuser, want.status));
        end
      end
      m_tready <= !hold && (quiet || $urandom_range(99) >= 36);
    end
  end

  // Back pressure: once asked, the receiver stops taking results for a long
  // stretch while the sender keeps offering, so the block fills and stalls.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold <= 1'b0;
  end

  task automatic push_write(input logic [INDEX_W-1:0] idx, input logic [WEIGHT_W-1:0] w);
    sampler_cmd_t c;
    c.cmd = CMD_WRITE;
    c.idx = idx;
    c.weight = w;
    c.uniform = $urandom;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  task automatic push_draw(input logic [UNIFORM_W-1:0] u);
    sampler_cmd_t c;
    c.cmd = CMD_DRAW;
    c.idx = INDEX_W'($urandom_range(NUM_CATS - 1));
    c.weight = WEIGHT_W'($urandom);
    c.uniform = u;
    cmd_q.insert(cmd_q.size(), c);
  endtask

  // Waits until every queued beat has been taken and every result checked.
  // Each beat gives exactly one result, so the block is idle then.
  task automatic drain();
    while (cmd_q.size() != 0 || s_tvalid || expected_samples.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register writes happen only with the block idle; the predictor total is
  // recomputed over the new range just as the block does.
  task automatic write_count(input logic [COUNT_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    cat_count = v;
    refresh_total();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random beats: writes lean toward categories in use and toward the weight
  // extremes, draws toward the uniform extremes, so the search covers empty
  // tables, zero-weight holes and single dominant categories.
  task automatic push_random();
    int unsigned n;
    int unsigned k;
    logic [WEIGHT_W-1:0] w;
    logic [UNIFORM_W-1:0] u;
    n = cats_in_use();
    if ($urandom_range(99) < 40) begin
      k = $urandom_range(99);
      if (k < 20) w = '0;
      else if (k < 30) w = '1;
      else if (k < 50) w = WEIGHT_W'($urandom_range(15, 1));
      else w = WEIGHT_W'($urandom);
      if (n != 0 && $urandom_range(99) < 75) push_write(INDEX_W'($urandom_range(n - 1)), w);
      else push_write(INDEX_W'($urandom_range(NUM_CATS - 1)), w);
    end else begin
      k = $urandom_range(99);
      if (k < 5) u = '0;
      else if (k < 10) u = '1;
      else u = $urandom;
      push_draw(u);
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] count_pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Single category in use. A draw against a zero total must report the
    // empty status; a write beyond the count stores without touching the total.
    write_count(7'd1);
    push_draw('0);
    push_write(6'd0, 16'd0);
    push_draw(32'h1234_5678);
    push_write(6'd0, 16'hFFFF);
    push_draw('0);
    push_draw('1);
    push_write(6'd63, 16'hFFFF);
    push_draw('1);

    // Full table: the weight stored at the top entry now counts, and holes of
    // weight zero must be skipped by the search.
    write_count(7'd64);
    push_write(6'd1, 16'd0);
    push_write(6'd5, 16'd1);
    push_draw('1);
    push_draw(32'h8000_0000);
    push_draw('0);

    // Count above the table size saturates at the table size.
    write_count(7'd127);
    push_draw(32'h7FFF_FFFF);
    push_write(6'd0, 16'd0);
    push_draw('0);

    // No category in use: every draw is empty, writes are plain echoes.
    write_count(7'd0);
    push_draw(32'hDEAD_BEEF);
    push_write(6'd2, 16'd7);
    push_draw('1);

    // Three categories in use, the first two of weight zero.
    write_count(7'd3);
    push_draw('1);
    push_write(6'd2, 16'd0);
    push_draw(32'h4000_0000);

    // Random phases with a new count each time. One phase runs with no idling
    // on either side, another with the long receiver hold-off.
    for (int p = 0; p < 6; p++) begin
      case ($urandom_range(5))
        0: count_pick = 7'd1;
        1: count_pick = 7'd2;
        2: count_pick = 7'd64;
        3: count_pick = 7'd100;
        default: count_pick = COUNT_W'($urandom_range(127));
      endcase
      write_count(count_pick);
      quiet = (p == 2);
      if (p == 4) pressure_go = 1'b1;
      for (int i = 0; i < 75; i++) push_random();
    end
    drain();
    quiet = 1'b0;

    // Let any stray result show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_samples.size() == 0) begin
      $display("categorical_sampler_tb OK");
    end else begin
      $display("categorical_sampler_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: the slowest correct run finishes far inside this.
  initial begin
    #800000;
    $display("categorical_sampler_tb NOT OK");
    $finish;
  end

endmodule
